// ===== rtl/double_ended_queue_defines.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// assertion macros used by the double ended queue rtl
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same cycle implication
`define DQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next cycle implication
`define DQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// types and constants of the double ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int OPCODE_W = 2;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_HEAD = 2'd0,
        OP_PUSH_TAIL = 2'd1,
        OP_POP_HEAD  = 2'd2,
        OP_POP_TAIL  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_POP_EMPTY  = 2'd1,
        STATUS_PUSH_FULL  = 2'd2,
        STATUS_UNUSED     = 2'd3
    } status_t;

    // operation broadcast to every cell, already qualified by full and empty
    typedef struct packed {
        logic push_head;
        logic push_tail;
        logic pop_head;
        logic pop_tail;
    } cell_ctrl_t;

endpackage

// ===== rtl/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell
// one storage cell of the deque chain; entries sit packed from cell zero
// ----------------------------------------------------------------------------
module dq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dq_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0] push_word,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic                  left_valid,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  right_valid,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  valid
);

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic                  valid_reg, valid_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        priority if (ctrl.push_head) begin
            data_next  = left_data;
            valid_next = left_valid;
        end else if (ctrl.pop_head) begin
            data_next  = right_data;
            valid_next = right_valid;
        end else if (ctrl.push_tail) begin
            // first free cell takes the word
            if (!valid_reg && left_valid) begin
                data_next  = push_word;
                valid_next = 1'b1;
            end
        end else if (ctrl.pop_tail) begin
            if (valid_reg && !right_valid) begin
                valid_next = 1'b0;
            end
        end else begin
            data_next  = data_reg;
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of DEPTH words built as a chain of shifting cells
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one transaction per operation, s_opcode selects push
//   head, push tail, pop head or pop tail; s_push_value is stored by pushes
//   result channel m_*: exactly one transaction per input transaction with
//   the popped word, status, entry count after the operation and empty flag
//   the result is registered and is valid in the cycle after the input is accepted
//   throughput: one operation per cycle while results are taken; each
//   operation updates the whole cell chain at once, the head sits in cell
//   zero and the tail is the last valid cell
//   a refused push (full) or pop (empty) changes nothing and is flagged
//   reset clears every cell valid bit, the count and the result valid flag;
//   the queue is empty and ready in the first cycle after reset
//   when the receiver stalls the result register holds and s_ready drops
//   until the pending result is taken
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dq_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [dq_pkg::FIELD_W-1:0]   s_push_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dq_pkg::FIELD_W-1:0]   m_pop_value,
    output logic [dq_pkg::STATUS_W-1:0]  m_status,
    output logic [dq_pkg::COUNT_W-1:0]   m_entry_count,
    output logic                         m_is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]      cell_valid;
    logic [DATA_WIDTH-1:0] left_data  [DEPTH];
    logic [DEPTH-1:0]      left_valid;
    logic [DATA_WIDTH-1:0] right_data [DEPTH];
    logic [DEPTH-1:0]      right_valid;
    logic [DATA_WIDTH-1:0] tail_sel   [DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic [dq_pkg::FIELD_W-1:0] pop_value_reg, pop_value_next;
    dq_pkg::status_t            status_reg, status_next;
    logic [dq_pkg::COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic                       is_empty_reg, is_empty_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    dq_pkg::op_t           op;
    dq_pkg::cell_ctrl_t    ctrl;
    logic [DATA_WIDTH-1:0] push_word;
    logic [DATA_WIDTH-1:0] popped;
    logic [DATA_WIDTH-1:0] tail_word;
    logic [DATA_WIDTH+dq_pkg::FIELD_W-1:0] push_wide;
    logic [DATA_WIDTH+dq_pkg::FIELD_W-1:0] pop_wide;
    logic [CNT_W+dq_pkg::COUNT_W-1:0]      count_wide;

    assign accept = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign op    = dq_pkg::op_t'(s_opcode);

    assign push_wide = {{DATA_WIDTH{1'b0}}, s_push_value};
    assign push_word = push_wide[DATA_WIDTH-1:0];

    always_comb begin
        ctrl = '0;
        if (accept) begin
            unique case (op)
                dq_pkg::OP_PUSH_HEAD: ctrl.push_head = !full;
                dq_pkg::OP_PUSH_TAIL: ctrl.push_tail = !full;
                dq_pkg::OP_POP_HEAD:  ctrl.pop_head  = !empty;
                dq_pkg::OP_POP_TAIL:  ctrl.pop_tail  = !empty;
                default:              ctrl = '0;
            endcase
        end
    end

    // neighbor wiring of the chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign left_data[gi]  = push_word;
                assign left_valid[gi] = 1'b1;
            end else begin : g_inner_left
                assign left_data[gi]  = cell_data[gi-1];
                assign left_valid[gi] = cell_valid[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_data[gi]  = '0;
                assign right_valid[gi] = 1'b0;
            end else begin : g_inner_right
                assign right_data[gi]  = cell_data[gi+1];
                assign right_valid[gi] = cell_valid[gi+1];
            end

            assign tail_sel[gi] = (cell_valid[gi] && !right_valid[gi]) ?
                                  cell_data[gi] : '0;

            dq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .push_word   (push_word),
                .left_data   (left_data[gi]),
                .left_valid  (left_valid[gi]),
                .right_data  (right_data[gi]),
                .right_valid (right_valid[gi]),
                .data        (cell_data[gi]),
                .valid       (cell_valid[gi])
            );
        end
    endgenerate

    // one-hot select of the tail cell
    always_comb begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tail_word = tail_word | tail_sel[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        popped     = '0;
        if (ctrl.push_head || ctrl.push_tail) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop_head) begin
            count_next = count_reg - 1'b1;
            popped     = cell_data[0];
        end else if (ctrl.pop_tail) begin
            count_next = count_reg - 1'b1;
            popped     = tail_word;
        end
    end

    assign pop_wide   = {{dq_pkg::FIELD_W{1'b0}}, popped};
    assign count_wide = {{dq_pkg::COUNT_W{1'b0}}, count_next};

    always_comb begin
        m_valid_next     = m_valid_reg;
        pop_value_next   = pop_value_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;
        is_empty_next    = is_empty_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next     = 1'b1;
            pop_value_next   = pop_wide[dq_pkg::FIELD_W-1:0];
            entry_count_next = count_wide[dq_pkg::COUNT_W-1:0];
            is_empty_next    = (count_next == '0);
            unique case (op)
                dq_pkg::OP_PUSH_HEAD, dq_pkg::OP_PUSH_TAIL: begin
                    status_next = full ? dq_pkg::STATUS_PUSH_FULL : dq_pkg::STATUS_OK;
                end
                dq_pkg::OP_POP_HEAD, dq_pkg::OP_POP_TAIL: begin
                    status_next = empty ? dq_pkg::STATUS_POP_EMPTY : dq_pkg::STATUS_OK;
                end
                default: status_next = dq_pkg::STATUS_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        pop_value_reg   <= pop_value_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
        is_empty_reg    <= is_empty_next;
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pop_value   = pop_value_reg;
    assign m_status      = status_reg;
    assign m_entry_count = entry_count_reg;
    assign m_is_empty    = is_empty_reg;

    // checks
    `DQ_ASSERT_IMP(a_count_matches_cells, aclk, aresetn, 1'b1,
        $countones(cell_valid) == int'(count_reg))
    `DQ_ASSERT_IMP(a_cells_packed, aclk, aresetn, 1'b1,
        (cell_valid & (cell_valid + 1'b1)) == '0)
    `DQ_ASSERT_NXT(a_refused_push_holds, aclk, aresetn,
        accept && full && (op == dq_pkg::OP_PUSH_HEAD || op == dq_pkg::OP_PUSH_TAIL),
        $stable(cell_valid) && $stable(count_reg))
    `DQ_ASSERT_IMP(a_refused_pop_zero, aclk, aresetn,
        m_valid_reg && status_reg == dq_pkg::STATUS_POP_EMPTY,
        pop_value_reg == '0 && is_empty_reg)

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the double ended queue: a shadow deque predicts the
// popped word, status, count and empty flag of every transaction; directed
// edge cases are followed by random operation mixes with random stalls on
// both channels
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 16;
    localparam int DATA_WIDTH     = 32;
    localparam int SLOT_W         = $clog2(DEPTH);
    localparam int RANDOM_ITEMS   = 1750;
    localparam int QUIET_ITEMS    = 200;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        logic [dq_pkg::FIELD_W-1:0] pop_value;
        dq_pkg::status_t            status;
        logic [dq_pkg::COUNT_W-1:0] entry_count;
        logic                       is_empty;
    } outcome_t;

    class deque_shadow;
        logic [dq_pkg::FIELD_W-1:0] ring_words [DEPTH];
        logic [SLOT_W-1:0]          head_slot;
        logic [SLOT_W-1:0]          tail_slot;
        logic [dq_pkg::COUNT_W-1:0] held;
        outcome_t                   due_outcomes [$];
        int                         failures;

        function new();
            head_slot = '0;
            tail_slot = '0;
            held      = '0;
            failures  = 0;
        endfunction

        function int pending();
            return due_outcomes.size();
        endfunction

        function void note_op(dq_pkg::op_t op, logic [dq_pkg::FIELD_W-1:0] word);
            outcome_t o;
            o.pop_value = '0;
            o.status    = dq_pkg::STATUS_OK;
            case (op)
                dq_pkg::OP_PUSH_HEAD: begin
                    if (held == DEPTH) begin
                        o.status = dq_pkg::STATUS_PUSH_FULL;
                    end else begin
                        head_slot = head_slot - 1'b1;
                        ring_words[head_slot] = word;
                        held = held + 1'b1;
                    end
                end
                dq_pkg::OP_PUSH_TAIL: begin
                    if (held == DEPTH) begin
                        o.status = dq_pkg::STATUS_PUSH_FULL;
                    end else begin
                        ring_words[tail_slot] = word;
                        tail_slot = tail_slot + 1'b1;
                        held = held + 1'b1;
                    end
                end
                dq_pkg::OP_POP_HEAD: begin
                    if (held == 0) begin
                        o.status = dq_pkg::STATUS_POP_EMPTY;
                    end else begin
                        o.pop_value = ring_words[head_slot];
                        head_slot = head_slot + 1'b1;
                        held = held - 1'b1;
                    end
                end
                default: begin
                    if (held == 0) begin
                        o.status = dq_pkg::STATUS_POP_EMPTY;
                    end else begin
                        tail_slot = tail_slot - 1'b1;
                        o.pop_value = ring_words[tail_slot];
                        held = held - 1'b1;
                    end
                end
            endcase
            o.entry_count = held;
            o.is_empty    = (held == 0);
            due_outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [dq_pkg::FIELD_W-1:0]  pop_value,
                                    logic [dq_pkg::STATUS_W-1:0] status,
                                    logic [dq_pkg::COUNT_W-1:0]  entry_count,
                                    logic                        is_empty);
            outcome_t want;
            if (due_outcomes.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual pop_value %h",
                         $time, pop_value);
                failures++;
                return;
            end
            want = due_outcomes.pop_front();
            if (pop_value !== want.pop_value) begin
                $display("%0t: pop_value expected %h actual %h", $time, want.pop_value, pop_value);
                failures++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                failures++;
            end
            if (entry_count !== want.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                         entry_count);
                failures++;
            end
            if (is_empty !== want.is_empty) begin
                $display("%0t: is_empty expected %b actual %b", $time, want.is_empty, is_empty);
                failures++;
            end
        endfunction
    endclass

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic [dq_pkg::OPCODE_W-1:0] s_opcode      = '0;
    logic [dq_pkg::FIELD_W-1:0]  s_push_value  = '0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic [dq_pkg::FIELD_W-1:0]  m_pop_value;
    logic [dq_pkg::STATUS_W-1:0] m_status;
    logic [dq_pkg::COUNT_W-1:0]  m_entry_count;
    logic                        m_is_empty;

    deque_shadow shadow;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    bit          hold_off_req = 1'b0;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_push_value  (s_push_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pop_value   (m_pop_value),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_is_empty    (m_is_empty)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [dq_pkg::FIELD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(input dq_pkg::op_t op, input logic [dq_pkg::FIELD_W-1:0] word);
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_push_value <= word;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // transaction monitor: inputs are noted before results are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                shadow.note_op(dq_pkg::op_t'(s_opcode), s_push_value);
            end
            if (m_valid && m_ready) begin
                shadow.check_outcome(m_pop_value, m_status, m_entry_count, m_is_empty);
            end
        end
    end

    initial begin : receiver
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int          push_pct;
        dq_pkg::op_t op;
        shadow   = new();
        push_pct = 50;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        gap_pct   = 20;
        stall_pct = 20;

        // empty pops, then a single entry taken from each end
        send_op(dq_pkg::OP_POP_HEAD, $urandom());
        send_op(dq_pkg::OP_POP_TAIL, $urandom());
        send_op(dq_pkg::OP_PUSH_TAIL, '1);
        send_op(dq_pkg::OP_POP_TAIL, $urandom());
        send_op(dq_pkg::OP_PUSH_HEAD, '0);
        send_op(dq_pkg::OP_POP_HEAD, $urandom());
        send_op(dq_pkg::OP_PUSH_HEAD, '1);
        send_op(dq_pkg::OP_POP_TAIL, $urandom());

        // fill from both ends, then refused pushes
        for (int i = 0; i < DEPTH; i++) begin
            send_op(i[0] ? dq_pkg::OP_PUSH_TAIL : dq_pkg::OP_PUSH_HEAD, random_word());
        end
        send_op(dq_pkg::OP_PUSH_HEAD, '1);
        send_op(dq_pkg::OP_PUSH_TAIL, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                push_pct  = 25 * $urandom_range(1, 3);
                gap_pct   = 15 * $urandom_range(0, 2);
                stall_pct = 15 * $urandom_range(0, 2);
            end
            if (i == 300) begin
                hold_off_req = 1'b1;
                gap_pct      = 0;
            end
            if (i == 900) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (shadow.pending() != 0) @(posedge aclk);
            end
            if (i >= RANDOM_ITEMS - QUIET_ITEMS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            if ($urandom_range(0, 99) < push_pct) begin
                op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_TAIL : dq_pkg::OP_PUSH_HEAD;
            end else begin
                op = $urandom_range(0, 1) ? dq_pkg::OP_POP_TAIL : dq_pkg::OP_POP_HEAD;
            end
            send_op(op, random_word());
        end

        s_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.failures == 0 && shadow.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
